@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the clique counter, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define KCC_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define KCC_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/kcc_pkg.sv @@
// Package of the clique counter: sizes, command and register codes, state type.
package kcc_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int MAX_CLIQUE   = 16;

  localparam int VW      = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int DW      = $clog2(MAX_CLIQUE);
  localparam int DEG_W   = $clog2(MAX_VERTICES);
  localparam int FRAME_W = CNT_W + MAX_VERTICES;

  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Configuration register indexes
  localparam logic REG_CLIQUE_SIZE  = 1'b0;
  localparam logic REG_VERTEX_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_RDA,
    ST_E_CHKA,
    ST_E_RDB,
    ST_E_WRB,
    ST_D_RDA,
    ST_D_WRA,
    ST_D_RDB,
    ST_D_WRB,
    ST_C_SWEEP,
    ST_C_ROOT,
    ST_C_ROOTRD,
    ST_S_STEP,
    ST_S_PUSH,
    ST_S_POP,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/k_clique_counter.sv @@
// Top level of the clique counter: command sequencer, search engine and stores.
//
// Clique counter. A command word is taken when start is high and busy is low.
// Clear is done without leaving idle; add-edge takes both adjacency rows
// and both degree entries through read-modify-write on single-port RAMs
// (a duplicate edge ends after the first row is checked; a self loop is
// ignored). A count whose clique size or vertex count leaves nothing to
// search goes straight to done. Otherwise count first sweeps the degree RAM
// over the vertices in use, then walks the search tree: roots whose degree
// qualifies have their row read, candidates are scanned in turn, and frames
// are pushed and popped. The one result word is clique_count, on done for
// exactly one cycle; the receiver cannot stall it. Configuration writes are
// always ready and must come only while busy is low.
module k_clique_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [6:0]  vertex_a,
  input  logic [6:0]  vertex_b,
  output logic        done,
  output logic [31:0] clique_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int MV = kcc_pkg::MAX_VERTICES;
  localparam int VW = kcc_pkg::VW;
  localparam int CW = kcc_pkg::CNT_W;
  localparam int DW = kcc_pkg::DW;
  localparam int GW = kcc_pkg::DEG_W;
  localparam int FW = kcc_pkg::FRAME_W;

  kcc_pkg::state_t state, state_next;

  // control registers
  logic [4:0]    csize;
  logic [7:0]    vcount;
  logic [31:0]   total, total_next;
  logic [MV-1:0] row_valid, row_valid_next;
  logic [MV-1:0] deg_valid, deg_valid_next;
  logic          pend, pend_next;

  // payload registers
  logic [VW-1:0] ea, ea_next, eb, eb_next;
  logic [CW-1:0] sw_cnt, sw_cnt_next;
  logic [VW-1:0] sw_prev, sw_prev_next;
  logic [CW-1:0] root, root_next;
  logic [CW-1:0] scan, scan_next;
  logic [DW-1:0] depth, depth_next;
  logic [MV-1:0] mask, mask_next;
  logic [MV-1:0] eligible, eligible_next;
  logic          rd_row_valid, rd_deg_valid;

  // RAM ports
  logic          adj_we;
  logic [VW-1:0] adj_addr;
  logic [MV-1:0] adj_wdata, adj_rdata;
  logic          deg_we;
  logic [VW-1:0] deg_addr;
  logic [GW-1:0] deg_wdata, deg_rdata;
  logic          frm_we;
  logic [DW-1:0] frm_addr;
  logic [FW-1:0] frm_wdata, frm_rdata;

  kcc_ram #(.WIDTH(MV), .DEPTH(MV)) u_adj (
    .clk(clk), .we(adj_we), .addr(adj_addr), .wdata(adj_wdata), .rdata(adj_rdata)
  );

  kcc_ram #(.WIDTH(GW), .DEPTH(MV)) u_deg (
    .clk(clk), .we(deg_we), .addr(deg_addr), .wdata(deg_wdata), .rdata(deg_rdata)
  );

  kcc_ram #(.WIDTH(FW), .DEPTH(kcc_pkg::MAX_CLIQUE)) u_frm (
    .clk(clk), .we(frm_we), .addr(frm_addr), .wdata(frm_wdata), .rdata(frm_rdata)
  );

  // shared conditions
  logic          accept;
  logic          edge_ok;
  logic [CW-1:0] n_eff;
  logic          trivial;
  logic [31:0]   trivial_val;
  logic [MV-1:0] row_data;
  logic [GW-1:0] deg_data;
  logic          saturated;
  logic          scan_end;
  logic          hit;
  logic          complete;
  logic [MV-1:0] one_hot;

  assign accept    = start && !busy;
  assign edge_ok   = (32'(vertex_a) < MV) && (32'(vertex_b) < MV) && (vertex_a != vertex_b);
  assign n_eff     = (32'(vcount) > MV) ? CW'(MV) : CW'(vcount);
  assign trivial   = (csize == 5'd0) || (32'(csize) > kcc_pkg::MAX_CLIQUE) ||
                     (n_eff == '0) || (csize == 5'd1);
  assign trivial_val = (csize == 5'd1 && n_eff != '0) ? 32'(n_eff) : 32'd0;
  assign row_data  = rd_row_valid ? adj_rdata : '0;
  assign deg_data  = rd_deg_valid ? deg_rdata : '0;
  assign saturated = (total == kcc_pkg::TOTAL_MAX);
  assign scan_end  = (scan >= n_eff);
  assign hit       = eligible[scan[VW-1:0]] && mask[scan[VW-1:0]];
  assign complete  = (32'(depth) + 32'd2) == 32'(csize);
  assign one_hot   = {{(MV-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kcc_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == kcc_pkg::CMD_ADD && edge_ok) begin
            state_next = kcc_pkg::ST_E_RDA;
          end else if (cmd == kcc_pkg::CMD_COUNT) begin
            state_next = trivial ? kcc_pkg::ST_DONE : kcc_pkg::ST_C_SWEEP;
          end
        end
      end
      kcc_pkg::ST_E_RDA:  state_next = kcc_pkg::ST_E_CHKA;
      kcc_pkg::ST_E_CHKA: state_next = row_data[eb] ? kcc_pkg::ST_IDLE : kcc_pkg::ST_E_RDB;
      kcc_pkg::ST_E_RDB:  state_next = kcc_pkg::ST_E_WRB;
      kcc_pkg::ST_E_WRB:  state_next = kcc_pkg::ST_D_RDA;
      kcc_pkg::ST_D_RDA:  state_next = kcc_pkg::ST_D_WRA;
      kcc_pkg::ST_D_WRA:  state_next = kcc_pkg::ST_D_RDB;
      kcc_pkg::ST_D_RDB:  state_next = kcc_pkg::ST_D_WRB;
      kcc_pkg::ST_D_WRB:  state_next = kcc_pkg::ST_IDLE;
      kcc_pkg::ST_C_SWEEP: begin
        if (sw_cnt == n_eff) state_next = kcc_pkg::ST_C_ROOT;
      end
      kcc_pkg::ST_C_ROOT: begin
        if (root >= n_eff || saturated) begin
          state_next = kcc_pkg::ST_DONE;
        end else if (eligible[root[VW-1:0]]) begin
          state_next = kcc_pkg::ST_C_ROOTRD;
        end
      end
      kcc_pkg::ST_C_ROOTRD: state_next = kcc_pkg::ST_S_STEP;
      kcc_pkg::ST_S_STEP: begin
        if (saturated) begin
          state_next = kcc_pkg::ST_DONE;
        end else if (scan_end) begin
          state_next = (depth == '0) ? kcc_pkg::ST_C_ROOT : kcc_pkg::ST_S_POP;
        end else if (hit && !complete) begin
          state_next = kcc_pkg::ST_S_PUSH;
        end
      end
      kcc_pkg::ST_S_PUSH: state_next = kcc_pkg::ST_S_STEP;
      kcc_pkg::ST_S_POP:  state_next = kcc_pkg::ST_S_STEP;
      kcc_pkg::ST_DONE:   state_next = kcc_pkg::ST_IDLE;
      default:            state_next = kcc_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    total_next     = total;
    row_valid_next = row_valid;
    deg_valid_next = deg_valid;
    pend_next      = 1'b0;
    ea_next        = ea;
    eb_next        = eb;
    sw_cnt_next    = sw_cnt;
    sw_prev_next   = sw_prev;
    root_next      = root;
    scan_next      = scan;
    depth_next     = depth;
    mask_next      = mask;
    eligible_next  = eligible;
    adj_we         = 1'b0;
    adj_addr       = ea;
    adj_wdata      = row_data;
    deg_we         = 1'b0;
    deg_addr       = ea;
    deg_wdata      = deg_data + GW'(1);
    frm_we         = 1'b0;
    frm_addr       = depth;
    frm_wdata      = {scan, mask};
    case (state)
      kcc_pkg::ST_IDLE: begin
        ea_next     = VW'(vertex_a);
        eb_next     = VW'(vertex_b);
        sw_cnt_next = '0;
        root_next   = '0;
        if (accept && cmd == kcc_pkg::CMD_CLEAR) begin
          row_valid_next = '0;
          deg_valid_next = '0;
        end
        if (accept && cmd == kcc_pkg::CMD_COUNT) begin
          total_next = trivial ? trivial_val : 32'd0;
        end
      end
      kcc_pkg::ST_E_RDA: adj_addr = ea;
      kcc_pkg::ST_E_CHKA: begin
        adj_addr  = ea;
        adj_wdata = row_data | (one_hot << eb);
        if (!row_data[eb]) begin
          adj_we            = 1'b1;
          row_valid_next[ea] = 1'b1;
        end
      end
      kcc_pkg::ST_E_RDB: adj_addr = eb;
      kcc_pkg::ST_E_WRB: begin
        adj_addr           = eb;
        adj_wdata          = row_data | (one_hot << ea);
        adj_we             = 1'b1;
        row_valid_next[eb] = 1'b1;
      end
      kcc_pkg::ST_D_RDA: deg_addr = ea;
      kcc_pkg::ST_D_WRA: begin
        deg_addr           = ea;
        deg_we             = 1'b1;
        deg_valid_next[ea] = 1'b1;
      end
      kcc_pkg::ST_D_RDB: deg_addr = eb;
      kcc_pkg::ST_D_WRB: begin
        deg_addr           = eb;
        deg_we             = 1'b1;
        deg_valid_next[eb] = 1'b1;
      end
      kcc_pkg::ST_C_SWEEP: begin
        // one degree read issued per cycle, result lands in the next cycle
        deg_addr = sw_cnt[VW-1:0];
        if (sw_cnt < n_eff) begin
          sw_cnt_next  = sw_cnt + CW'(1);
          sw_prev_next = sw_cnt[VW-1:0];
          pend_next    = 1'b1;
        end
        if (pend) begin
          eligible_next[sw_prev] = (32'(deg_data) + 32'd1) >= 32'(csize);
        end
      end
      kcc_pkg::ST_C_ROOT: begin
        adj_addr = root[VW-1:0];
        if (root < n_eff && !eligible[root[VW-1:0]]) begin
          root_next = root + CW'(1);
        end
      end
      kcc_pkg::ST_C_ROOTRD: begin
        mask_next  = row_data;
        depth_next = '0;
        scan_next  = root + CW'(1);
        root_next  = root + CW'(1);
      end
      kcc_pkg::ST_S_STEP: begin
        adj_addr  = scan[VW-1:0];
        frm_wdata = {scan + CW'(1), mask};
        if (!saturated) begin
          if (scan_end) begin
            if (depth != '0) begin
              frm_addr   = depth - DW'(1);
              depth_next = depth - DW'(1);
            end
          end else begin
            scan_next = scan + CW'(1);
            if (hit) begin
              if (complete) begin
                total_next = total + 32'd1;
              end else begin
                frm_we = 1'b1;
              end
            end
          end
        end
      end
      kcc_pkg::ST_S_PUSH: begin
        mask_next  = mask & row_data;
        depth_next = depth + DW'(1);
      end
      kcc_pkg::ST_S_POP: begin
        scan_next = frm_rdata[FW-1:MV];
        mask_next = frm_rdata[MV-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kcc_pkg::ST_IDLE;
      csize     <= 5'd3;
      vcount    <= 8'd128;
      total     <= '0;
      row_valid <= '0;
      deg_valid <= '0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      row_valid <= row_valid_next;
      deg_valid <= deg_valid_next;
      pend      <= pend_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kcc_pkg::REG_CLIQUE_SIZE) csize <= cfg_data[4:0];
        if (cfg_index == kcc_pkg::REG_VERTEX_COUNT) vcount <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ea           <= ea_next;
    eb           <= eb_next;
    sw_cnt       <= sw_cnt_next;
    sw_prev      <= sw_prev_next;
    root         <= root_next;
    scan         <= scan_next;
    depth        <= depth_next;
    mask         <= mask_next;
    eligible     <= eligible_next;
    rd_row_valid <= row_valid[adj_addr];
    rd_deg_valid <= deg_valid[deg_addr];
  end

  // outputs
  always_comb begin
    busy         = (state != kcc_pkg::ST_IDLE);
    done         = (state == kcc_pkg::ST_DONE);
    clique_count = total;
    cfg_ready    = 1'b1;
  end

`include "assert_macros.svh"

  `KCC_ASSERT_IMP(a_done_busy, done, busy, "result outside a command")
  `KCC_ASSERT_NXT(a_done_once, done, !done, "result strobe longer than one cycle")
  `KCC_ASSERT_NXT(a_count_busy, accept && cmd == kcc_pkg::CMD_COUNT, busy, "count not started")
  `KCC_ASSERT_IMP(a_depth_bound, state == kcc_pkg::ST_S_STEP, (32'(depth) + 32'd2) <= 32'(csize), "search depth past clique size")

endmodule

@@ hw/rtl/kcc_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ test/k_clique_counter_tb.sv @@
// Testbench of the clique counter: directed table, then random graph phases, checked live.
module k_clique_counter_tb;

  localparam int ROW_ITEM = 0;
  localparam int ROW_CFG  = 1;
  localparam logic [1:0] CMD_CLR  = kcc_pkg::CMD_CLEAR;
  localparam logic [1:0] CMD_EDGE = kcc_pkg::CMD_ADD;
  localparam logic [1:0] CMD_CNT  = kcc_pkg::CMD_COUNT;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic       RCS      = kcc_pkg::REG_CLIQUE_SIZE;
  localparam logic       RVC      = kcc_pkg::REG_VERTEX_COUNT;
  localparam int         NV       = kcc_pkg::MAX_VERTICES;
  localparam int         NK       = kcc_pkg::MAX_CLIQUE;

  typedef struct {
    int          kind;
    logic [1:0]  cmd;
    logic [6:0]  a;
    logic [6:0]  b;
    logic        idx;
    logic [7:0]  data;
    logic        typed;
    logic [31:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = CMD_CLR;
  logic [6:0]  vertex_a = '0;
  logic [6:0]  vertex_b = '0;
  logic        done;
  logic [31:0] clique_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = RCS;
  logic [7:0]  cfg_data = '0;

  // Shadow graph and registers
  logic [NV-1:0] adj_row [NV];
  int          deg [NV];
  int          size_reg;
  int          nvert_reg;
  logic [31:0] pending_counts [$];
  int          err_cnt = 0;
  int          item_cnt = 0;

  k_clique_counter dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Backtracking count over the shadow graph
  function automatic logic [31:0] predict_count();
    int k;
    int n;
    int depth;
    int v;
    bit ok;
    int stk [NK];
    int pos [NK];
    logic [31:0] total;
    k = size_reg;
    n = (nvert_reg > NV) ? NV : nvert_reg;
    total = 0;
    if (k == 0 || k > NK || n == 0) return 0;
    if (k == 1) return n;
    for (int s = 0; s < n && total != kcc_pkg::TOTAL_MAX; s++) begin
      if (deg[s] < k - 1) continue;
      depth = 0;
      stk[0] = s;
      pos[0] = s + 1;
      while (depth >= 0 && total != kcc_pkg::TOTAL_MAX) begin
        v = pos[depth];
        if (v >= n) begin
          depth--;
          continue;
        end
        pos[depth] = v + 1;
        if (deg[v] < k - 1) continue;
        ok = 1;
        for (int i = 0; i <= depth; i++)
          if (!adj_row[stk[i]][v]) begin
            ok = 0;
            break;
          end
        if (!ok) continue;
        if (depth + 2 == k) total++;
        else begin
          depth++;
          stk[depth] = v;
          pos[depth] = v + 1;
        end
      end
    end
    return total;
  endfunction

  // Apply one accepted word to the shadow state
  task automatic apply_word(input logic [1:0] c, input logic [6:0] a, input logic [6:0] b,
                            input logic typed, input logic [31:0] value);
    case (c)
      CMD_CLR: begin
        foreach (adj_row[i]) adj_row[i] = '0;
        foreach (deg[i]) deg[i] = 0;
      end
      CMD_EDGE: begin
        if (a != b && !adj_row[a][b]) begin
          adj_row[a][b] = 1'b1;
          adj_row[b][a] = 1'b1;
          deg[a]++;
          deg[b]++;
        end
      end
      CMD_CNT: pending_counts = {pending_counts, (typed ? value : predict_count())};
      default: ;
    endcase
  endtask

  // Send one command word after a random gap
  task automatic send_word(input logic [1:0] c, input logic [6:0] a, input logic [6:0] b,
                           input logic typed = 1'b0, input logic [31:0] value = 0);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (busy);
    apply_word(c, a, b, typed, value);
    item_cnt++;
  endtask

  // Let the block drain, then write one register
  task automatic write_reg(input logic idx, input logic [7:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RCS) size_reg = data[4:0];
    else nvert_reg = data;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0)
        report_mismatch($sformatf("unexpected count %0d", clique_count));
      else begin
        if (clique_count !== pending_counts[0])
          report_mismatch($sformatf("clique_count %0d, want %0d",
                                    clique_count, pending_counts[0]));
        void'(pending_counts.pop_front());
      end
    end
  end

  row_t dir_rows [$];

  initial begin
    int k;
    int n;
    int hi;
    foreach (adj_row[i]) adj_row[i] = '0;
    foreach (deg[i]) deg[i] = 0;
    size_reg = 3;
    nvert_reg = 128;

    // Directed table
    dir_rows = '{
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd0,   7'd1,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd1,   7'd2,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd2,   7'd0,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd1,   7'd0,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd5,   7'd5,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_EDGE, 7'd127, 7'd126, RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd1},
      '{ROW_ITEM, CMD_NONE, 7'd127, 7'd127, RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RCS, 8'd1,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd128},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RVC, 8'd255, 1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd128},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RCS, 8'd2,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RVC, 8'd2,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd1},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RCS, 8'd20,  1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RCS, 8'd3,   1'b0, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RVC, 8'd0,   1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd0},
      '{ROW_ITEM, CMD_CLR,  7'd0,   7'd0,   RCS, 8'd0,   1'b0, 32'd0},
      '{ROW_CFG,  CMD_NONE, 7'd0,   7'd0,   RVC, 8'd128, 1'b0, 32'd0},
      '{ROW_ITEM, CMD_CNT,  7'd0,   7'd0,   RCS, 8'd0,   1'b1, 32'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      else
        send_word(dir_rows[r].cmd, dir_rows[r].a, dir_rows[r].b,
                  dir_rows[r].typed, dir_rows[r].value);
    end

    // Random phases: fresh settings and a fresh graph each time
    while (item_cnt < 630) begin
      case ($urandom_range(0, 9))
        0:       k = $urandom_range(0, 1);
        1:       k = $urandom_range(16, 31);
        default: k = $urandom_range(2, 5);
      endcase
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(0, 1);
        1:       n = $urandom_range(128, 255);
        default: n = $urandom_range(4, 24);
      endcase
      write_reg(RCS, {3'($urandom), 5'(k)});
      write_reg(RVC, 8'(n));
      hi = (n > 2 && n < 128) ? n - 1 : 20;
      send_word(CMD_CLR, 7'($urandom), 7'($urandom));
      repeat ($urandom_range(15, 40)) begin
        case ($urandom_range(0, 19))
          0:       send_word(CMD_NONE, 7'($urandom), 7'($urandom));
          1:       send_word(CMD_EDGE, 7'($urandom), 7'($urandom));
          2: begin
            n = $urandom_range(0, hi);
            send_word(CMD_EDGE, 7'(n), 7'(n));
          end
          3, 4, 5: send_word(CMD_CNT, 7'($urandom), 7'($urandom));
          6:       if ($urandom_range(0, 3) == 0)
                     send_word(CMD_CLR, 7'($urandom), 7'($urandom));
          default: send_word(CMD_EDGE, 7'($urandom_range(0, hi)), 7'($urandom_range(0, hi)));
        endcase
      end
      send_word(CMD_CNT, 7'($urandom), 7'($urandom));
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_counts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
